FILE: hdl/c2d_pkg.sv
// shared types, constants and helpers for the clamped-edge 2-d convolution
`default_nettype none
package c2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINES      = 5;
  localparam int HIST       = LINES - 1;
  localparam int PIX_W      = 8;
  localparam int KSIZE      = 5;
  localparam int COL_AW     = $clog2(MAX_WIDTH);
  localparam int DIM_W      = $clog2(MAX_WIDTH) + 1;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 21;
  localparam int LAG_W      = 12;
  localparam int SEL_W      = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int Q_CW       = 3;
  localparam int PROD_W     = 17;
  localparam int ROW_W      = 20;
  localparam int SUM_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_MODE  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_COEF_BANK0   = 3'd3,
    REG_COEF_BANK1   = 3'd4,
    REG_COEF_BANK2   = 3'd5,
    REG_COEF_BANK3   = 3'd6
  } c2d_reg_t;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } c2d_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered_value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_end;
  } c2d_out_t;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CNT_W-1:0] total;
    logic [LAG_W-1:0] rw;
    logic [LAG_W-1:0] lag;
    logic [CNT_W-1:0] totlag;
  } c2d_cfg_t;

  typedef struct packed {
    logic [63:0]      bank0;
    logic [63:0]      bank1;
    logic [63:0]      bank2;
    logic [PIX_W-1:0] bank3;
  } c2d_coef_t;

  // one column of the window, top row first, plus what the back end needs
  typedef struct packed {
    logic [KSIZE-1:0][PIX_W-1:0] vcol;
    logic                        emit;
    logic                        frame_end;
    logic [POS_W-1:0]            row;
    logic [POS_W-1:0]            col;
    logic [KSIZE-1:0][SEL_W-1:0] htap;
  } c2d_col_t;

  function automatic logic [PIX_W-1:0] c2d_pick_pix(
    input logic [KSIZE-1:0][PIX_W-1:0] v,
    input logic [SEL_W-1:0]            s
  );
    logic [PIX_W-1:0] r;
    case (s)
      3'd0: r = v[0];
      3'd1: r = v[1];
      3'd2: r = v[2];
      3'd3: r = v[3];
      3'd4: r = v[4];
      default: r = v[0];
    endcase
    return r;
  endfunction

  function automatic logic [KSIZE-1:0][PIX_W-1:0] c2d_pick_col(
    input logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] sr,
    input logic [SEL_W-1:0]                       s
  );
    logic [KSIZE-1:0][PIX_W-1:0] r;
    case (s)
      3'd0: r = sr[0];
      3'd1: r = sr[1];
      3'd2: r = sr[2];
      3'd3: r = sr[3];
      3'd4: r = sr[4];
      default: r = sr[0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/c2d_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/c2d_front.sv
// front end: item counters, column history ram and vertical edge clamping
`default_nettype none
module c2d_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire c2d_pkg::c2d_cfg_t  cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire c2d_pkg::c2d_in_t   in_data,
  input  wire logic [c2d_pkg::Q_CW-1:0] q_cnt,
  output logic                    push,
  output c2d_pkg::c2d_col_t       push_data
);

  localparam int HW = c2d_pkg::HIST * c2d_pkg::PIX_W;

  logic [c2d_pkg::CNT_W-1:0] p_r, p_nxt, p_cur;
  logic [c2d_pkg::DIM_W-1:0] pr_r, pr_nxt, pr_cur;
  logic [c2d_pkg::POS_W-1:0] pc_r, pc_nxt, pc_cur;
  logic [c2d_pkg::POS_W-1:0] or_r, or_nxt, or_cur;
  logic [c2d_pkg::POS_W-1:0] oc_r, oc_nxt, oc_cur;
  logic accept, restart, wr, feed, emit, fe;
  logic [c2d_pkg::SEL_W-1:0] rad;
  logic [c2d_pkg::KSIZE-1:0][c2d_pkg::SEL_W-1:0] htap;

  logic                      s1_vld_r, s1_wr_r, s1_feed_r, s1_emit_r, s1_fe_r;
  logic [c2d_pkg::POS_W-1:0] s1_row_r, s1_col_r;
  logic [c2d_pkg::DIM_W-1:0] s1_pr_r;
  logic [c2d_pkg::PIX_W-1:0] s1_pix_r;
  logic [c2d_pkg::COL_AW-1:0] s1_addr_r;
  logic [c2d_pkg::KSIZE-1:0][c2d_pkg::SEL_W-1:0] s1_htap_r;

  logic                       wl_vld_r;
  logic [c2d_pkg::COL_AW-1:0] wl_addr_r;
  logic [HW-1:0]              wl_data_r;
  logic [HW-1:0]              rdata, hist, wdata;
  logic                       we;
  logic [c2d_pkg::KSIZE-1:0][c2d_pkg::PIX_W-1:0] lst, vcol;

  assign accept = in_valid && in_ready;
  assign in_ready = (({1'b0, q_cnt}) + {3'b000, s1_vld_r}) < 4'(c2d_pkg::Q_DEPTH);
  assign rad = cfg.mode ? 3'd2 : 3'd1;

  always_comb begin
    restart = p_r >= cfg.totlag;
    p_cur  = restart ? '0 : p_r;
    pr_cur = restart ? '0 : pr_r;
    pc_cur = restart ? '0 : pc_r;
    or_cur = restart ? '0 : or_r;
    oc_cur = restart ? '0 : oc_r;
    wr   = p_cur < cfg.total;
    feed = p_cur >= {9'b0, cfg.rw};
    emit = p_cur >= {9'b0, cfg.lag};
    fe   = emit && ({1'b0, or_cur} == cfg.h - 11'd1) && ({1'b0, oc_cur} == cfg.w - 11'd1);

    p_nxt  = p_r;
    pr_nxt = pr_r;
    pc_nxt = pc_r;
    or_nxt = or_r;
    oc_nxt = oc_r;
    if (accept) begin
      if (fe) begin
        p_nxt  = '0;
        pr_nxt = '0;
        pc_nxt = '0;
        or_nxt = '0;
        oc_nxt = '0;
      end else begin
        p_nxt  = p_cur + 21'd1;
        pr_nxt = pr_cur;
        pc_nxt = pc_cur + 10'd1;
        or_nxt = or_cur;
        oc_nxt = oc_cur;
        if ({1'b0, pc_cur} == cfg.w - 11'd1) begin
          pc_nxt = '0;
          pr_nxt = pr_cur + 11'd1;
        end
        if (emit) begin
          oc_nxt = oc_cur + 10'd1;
          if ({1'b0, oc_cur} == cfg.w - 11'd1) begin
            oc_nxt = '0;
            or_nxt = or_cur + 10'd1;
          end
        end
      end
    end
  end

  // shift-register tap for each window column, replicating the left and right edges
  always_comb begin
    logic signed [11:0] x, xc, wm1, tt;
    wm1 = $signed({1'b0, cfg.w}) - 12'sd1;
    for (int j = 0; j < c2d_pkg::KSIZE; j++) begin
      x  = $signed({2'b00, oc_cur}) + $signed(12'(j)) - 12'sd2;
      xc = x;
      if (x < 12'sd0) begin
        xc = 12'sd0;
      end else if (x > wm1) begin
        xc = wm1;
      end
      tt = $signed({9'b0, rad}) + $signed({2'b00, oc_cur}) - xc;
      htap[j] = tt[c2d_pkg::SEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r      <= '0;
      pr_r     <= '0;
      pc_r     <= '0;
      or_r     <= '0;
      oc_r     <= '0;
      s1_vld_r <= 1'b0;
      wl_vld_r <= 1'b0;
    end else begin
      p_r      <= p_nxt;
      pr_r     <= pr_nxt;
      pc_r     <= pc_nxt;
      or_r     <= or_nxt;
      oc_r     <= oc_nxt;
      s1_vld_r <= accept && (wr || feed);
      wl_vld_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r   <= wr;
      s1_feed_r <= feed;
      s1_emit_r <= emit;
      s1_fe_r   <= fe;
      s1_row_r  <= or_cur;
      s1_col_r  <= oc_cur;
      s1_pr_r   <= pr_cur;
      s1_pix_r  <= in_data.cmd ? '0 : in_data.pixel_in;
      s1_addr_r <= pc_cur;
      s1_htap_r <= htap;
    end
    wl_addr_r <= s1_addr_r;
    wl_data_r <= wdata;
  end

  c2d_ram #(
    .WIDTH (HW),
    .DEPTH (c2d_pkg::MAX_WIDTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .raddr (pc_cur),
    .rdata (rdata)
  );

  // the ram read misses a write to the same column in the previous cycle
  assign hist  = (wl_vld_r && (wl_addr_r == s1_addr_r)) ? wl_data_r : rdata;
  assign we    = s1_vld_r && s1_wr_r;
  assign wdata = {hist[HW-c2d_pkg::PIX_W-1:0], s1_pix_r};

  // rows newest first; past the last row the newest stored row stands in
  always_comb begin
    lst[0] = s1_wr_r ? s1_pix_r : hist[7:0];
    lst[1] = s1_wr_r ? hist[7:0]   : hist[15:8];
    lst[2] = s1_wr_r ? hist[15:8]  : hist[23:16];
    lst[3] = s1_wr_r ? hist[23:16] : hist[31:24];
    lst[4] = hist[31:24];
  end

  always_comb begin
    logic signed [12:0] rr, hm1;
    logic [c2d_pkg::DIM_W-1:0] rc, bsel, ud;
    hm1  = $signed({2'b00, cfg.h}) - 13'sd1;
    bsel = s1_wr_r ? s1_pr_r : cfg.h - 11'd1;
    for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
      rr = $signed({2'b00, s1_pr_r}) - $signed({10'b0, rad}) + $signed(13'(i)) - 13'sd2;
      if (rr < 13'sd0) begin
        rc = '0;
      end else if (rr > hm1) begin
        rc = cfg.h - 11'd1;
      end else begin
        rc = rr[c2d_pkg::DIM_W-1:0];
      end
      ud = bsel - rc;
      vcol[i] = c2d_pkg::c2d_pick_pix(lst, ud[c2d_pkg::SEL_W-1:0]);
    end
  end

  assign push = s1_vld_r && s1_feed_r;
  always_comb begin
    push_data.vcol      = vcol;
    push_data.emit      = s1_emit_r;
    push_data.frame_end = s1_fe_r;
    push_data.row       = s1_row_r;
    push_data.col       = s1_col_r;
    push_data.htap      = s1_htap_r;
  end

endmodule
`default_nettype wire

FILE: hdl/c2d_fifo.sv
// short queue of window columns between front and back end
`default_nettype none
module c2d_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire c2d_pkg::c2d_col_t        push_data,
  input  wire logic                     pop,
  output c2d_pkg::c2d_col_t             pop_data,
  output logic                          empty,
  output logic [c2d_pkg::Q_CW-1:0]      count
);

  c2d_pkg::c2d_col_t        mem [c2d_pkg::Q_DEPTH];
  logic [c2d_pkg::Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [c2d_pkg::Q_CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  assign pop_data = mem[rp_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

endmodule
`default_nettype wire

FILE: hdl/c2d_back.sv
// back end: horizontal window, 25 products, adder tree and output register
`default_nettype none
module c2d_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               mode,
  input  wire c2d_pkg::c2d_coef_t coef,
  input  wire logic               q_empty,
  input  wire c2d_pkg::c2d_col_t  q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output c2d_pkg::c2d_out_t       out_data
);

  localparam int K = c2d_pkg::KSIZE;

  logic en;
  logic [K-1:0][K-1:0][c2d_pkg::PIX_W-1:0] sr_r, sr_nxt;
  logic [K-1:0][K-1:0][c2d_pkg::PIX_W-1:0] win_nxt, win_r;
  logic [K*K*c2d_pkg::PIX_W-1:0] coef_all;
  logic signed [c2d_pkg::PIX_W-1:0] coefg [K][K];

  logic                      b0_vld_r, b1_vld_r, b2_vld_r, out_vld_r;
  logic [c2d_pkg::POS_W-1:0] b0_row_r, b0_col_r, b1_row_r, b1_col_r, b2_row_r, b2_col_r;
  logic                      b0_fe_r, b1_fe_r, b2_fe_r;
  logic signed [c2d_pkg::PROD_W-1:0] prod_r [K][K];
  logic signed [c2d_pkg::ROW_W-1:0]  rsum_r [K];
  logic signed [c2d_pkg::ROW_W-1:0]  rsum_nxt [K];
  logic signed [c2d_pkg::SUM_W-1:0]  total_nxt;
  c2d_pkg::c2d_out_t out_r;

  assign en    = !out_vld_r || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    sr_nxt = sr_r;
    if (q_pop) begin
      sr_nxt[0] = q_data.vcol;
      for (int s = 1; s < K; s++) begin
        sr_nxt[s] = sr_r[s-1];
      end
    end
  end

  always_comb begin
    logic [K-1:0][c2d_pkg::PIX_W-1:0] c;
    for (int j = 0; j < K; j++) begin
      c = c2d_pkg::c2d_pick_col(sr_nxt, q_data.htap[j]);
      for (int i = 0; i < K; i++) begin
        win_nxt[i][j] = c[i];
      end
    end
  end

  // 3x3 kernels sit in the middle of the 5x5 grid
  assign coef_all = {coef.bank3, coef.bank2, coef.bank1, coef.bank0};
  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        if (mode) begin
          coefg[i][j] = $signed(coef_all[(i*5+j)*8 +: 8]);
        end else if (i >= 1 && i <= 3 && j >= 1 && j <= 3) begin
          coefg[i][j] = $signed(coef_all[((i-1)*3+(j-1))*8 +: 8]);
        end else begin
          coefg[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      rsum_nxt[i] = '0;
      for (int j = 0; j < K; j++) begin
        rsum_nxt[i] = rsum_nxt[i] + c2d_pkg::ROW_W'(prod_r[i][j]);
      end
    end
    total_nxt = '0;
    for (int i = 0; i < K; i++) begin
      total_nxt = total_nxt + c2d_pkg::SUM_W'(rsum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r  <= 1'b0;
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      b0_vld_r  <= q_pop && q_data.emit;
      b1_vld_r  <= b0_vld_r;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (en) begin
      win_r    <= win_nxt;
      b0_row_r <= q_data.row;
      b0_col_r <= q_data.col;
      b0_fe_r  <= q_data.frame_end;
      b1_row_r <= b0_row_r;
      b1_col_r <= b0_col_r;
      b1_fe_r  <= b0_fe_r;
      b2_row_r <= b1_row_r;
      b2_col_r <= b1_col_r;
      b2_fe_r  <= b1_fe_r;
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          prod_r[i][j] <= coefg[i][j] * $signed({1'b0, win_r[i][j]});
        end
        rsum_r[i] <= rsum_nxt[i];
      end
      out_r.filtered_value <= total_nxt;
      out_r.out_row        <= b2_row_r;
      out_r.out_col        <= b2_col_r;
      out_r.frame_end      <= b2_fe_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: hdl/conv2d_clamped_edge.sv
// top level of the streaming 3x3 / 5x5 convolution with replicated borders
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | in_data (cmd, pixel_in)
//  out_    | output    | out_valid / out_ready   | out_data (value, row, col, frame_end)
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one item per clock while in_ready is high; it drops when the 4-entry column queue and
// the ram read stage hold four columns, so a stalled output blocks input after a few
// items. a window's last column passes the read stage, queue, window, product, row-sum
// and output registers before out_valid rises; the column history ram (one read and one
// write per item) sets the one-per-clock pace. reset is synchronous; the column ram is
// not cleared and needs no clearing pass. derived totals settle through the size, total
// and lag registers after a size write; in_ready stays low after any write and reset.
`default_nettype none
module conv2d_clamped_edge (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire c2d_pkg::c2d_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output c2d_pkg::c2d_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                      kernel_mode_r;
  logic [c2d_pkg::DIM_W-1:0] image_width_r, image_height_r;
  c2d_pkg::c2d_coef_t        coef_r;
  logic [c2d_pkg::DIM_W-1:0] w_eff_r, h_eff_r, w_eff_nxt, h_eff_nxt;
  logic [c2d_pkg::CNT_W-1:0] total_r, totlag_r;
  logic [c2d_pkg::LAG_W-1:0] rw_r, lag_r;
  c2d_pkg::c2d_cfg_t         cfg;

  logic                      push, pop, q_empty;
  c2d_pkg::c2d_col_t         push_data, pop_data;
  logic [c2d_pkg::Q_CW-1:0]  q_cnt;
  logic                      front_ready, settled;
  logic [2:0]                settle_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r  <= 1'b0;
      image_width_r  <= c2d_pkg::DIM_W'(c2d_pkg::MAX_WIDTH);
      image_height_r <= c2d_pkg::DIM_W'(c2d_pkg::MAX_HEIGHT);
      coef_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (c2d_pkg::c2d_reg_t'(cfg_index))
        c2d_pkg::REG_KERNEL_MODE:  kernel_mode_r  <= cfg_data[0];
        c2d_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[c2d_pkg::DIM_W-1:0];
        c2d_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[c2d_pkg::DIM_W-1:0];
        c2d_pkg::REG_COEF_BANK0:   coef_r.bank0   <= cfg_data;
        c2d_pkg::REG_COEF_BANK1:   coef_r.bank1   <= cfg_data;
        c2d_pkg::REG_COEF_BANK2:   coef_r.bank2   <= cfg_data;
        c2d_pkg::REG_COEF_BANK3:   coef_r.bank3   <= cfg_data[c2d_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input waits while the derived sizes catch up with a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= 3'd4;
    end else if (settle_r != 3'd0) begin
      settle_r <= settle_r - 3'd1;
    end
  end

  assign settled  = (settle_r == 3'd0);
  assign in_ready = front_ready && settled;

  // sizes of zero act as one, oversize as the maximum
  always_comb begin
    if (image_width_r == '0) begin
      w_eff_nxt = c2d_pkg::DIM_W'(1);
    end else if (image_width_r > c2d_pkg::DIM_W'(c2d_pkg::MAX_WIDTH)) begin
      w_eff_nxt = c2d_pkg::DIM_W'(c2d_pkg::MAX_WIDTH);
    end else begin
      w_eff_nxt = image_width_r;
    end
    if (image_height_r == '0) begin
      h_eff_nxt = c2d_pkg::DIM_W'(1);
    end else if (image_height_r > c2d_pkg::DIM_W'(c2d_pkg::MAX_HEIGHT)) begin
      h_eff_nxt = c2d_pkg::DIM_W'(c2d_pkg::MAX_HEIGHT);
    end else begin
      h_eff_nxt = image_height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r  <= c2d_pkg::DIM_W'(c2d_pkg::MAX_WIDTH);
      h_eff_r  <= c2d_pkg::DIM_W'(c2d_pkg::MAX_HEIGHT);
      total_r  <= c2d_pkg::CNT_W'(c2d_pkg::MAX_WIDTH * c2d_pkg::MAX_HEIGHT);
      rw_r     <= c2d_pkg::LAG_W'(c2d_pkg::MAX_WIDTH);
      lag_r    <= c2d_pkg::LAG_W'(c2d_pkg::MAX_WIDTH + 1);
      totlag_r <= c2d_pkg::CNT_W'(c2d_pkg::MAX_WIDTH * c2d_pkg::MAX_HEIGHT
                                  + c2d_pkg::MAX_WIDTH + 1);
    end else begin
      w_eff_r  <= w_eff_nxt;
      h_eff_r  <= h_eff_nxt;
      total_r  <= c2d_pkg::CNT_W'(w_eff_r * h_eff_r);
      rw_r     <= kernel_mode_r ? {w_eff_r, 1'b0} : {1'b0, w_eff_r};
      lag_r    <= rw_r + (kernel_mode_r ? 12'd2 : 12'd1);
      totlag_r <= total_r + {9'b0, lag_r};
    end
  end

  always_comb begin
    cfg.mode   = kernel_mode_r;
    cfg.w      = w_eff_r;
    cfg.h      = h_eff_r;
    cfg.total  = total_r;
    cfg.rw     = rw_r;
    cfg.lag    = lag_r;
    cfg.totlag = totlag_r;
  end

  c2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid && settled),
    .in_ready  (front_ready),
    .in_data   (in_data),
    .q_cnt     (q_cnt),
    .push      (push),
    .push_data (push_data)
  );

  c2d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_cnt)
  );

  c2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (kernel_mode_r),
    .coef      (coef_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |->
      ({1'b0, out_data.out_row} == h_eff_r - 11'd1) &&
      ({1'b0, out_data.out_col} == w_eff_r - 11'd1))
    else $error("frame_end away from the last pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.out_col} < w_eff_r))
    else $error("output column beyond image width");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == 3'(c2d_pkg::Q_DEPTH)) |-> !push || pop)
    else $error("column queue overflow");
`endif

endmodule
`default_nettype wire

FILE: bench/conv2d_clamped_edge_tb.sv
// testbench for the clamped-edge 2-d convolution: scoreboard with predictor, drivers, phases
`timescale 1ns / 1ps
module conv2d_clamped_edge_tb;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam int   STORE_DEPTH = c2d_pkg::LINES * c2d_pkg::MAX_WIDTH;
  localparam int   CYCLE_LIMIT = 600000;

  class conv_scoreboard;
    logic        mode;
    logic [10:0] width_reg, height_reg;
    logic [63:0] bank0, bank1, bank2;
    logic [7:0]  bank3;
    logic [7:0]  pix_store [STORE_DEPTH];
    int unsigned seen;
    c2d_pkg::c2d_out_t expected_q[$];
    int          mismatches;
    int          results_checked;

    function new();
      mode = 1'b0; width_reg = 11'd1024; height_reg = 11'd1024;
      bank0 = '0; bank1 = '0; bank2 = '0; bank3 = '0;
      foreach (pix_store[i]) pix_store[i] = '0;
      seen = 0; mismatches = 0; results_checked = 0;
    endfunction

    function int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned eff_w(); return clamp_dim(width_reg, c2d_pkg::MAX_WIDTH); endfunction
    function int unsigned eff_h(); return clamp_dim(height_reg, c2d_pkg::MAX_HEIGHT); endfunction
    function int unsigned radius(); return mode ? 2 : 1; endfunction
    function int unsigned frame_lag(); return radius() * eff_w() + radius(); endfunction

    function void set_reg(c2d_pkg::c2d_reg_t idx, logic [63:0] v);
      case (idx)
        c2d_pkg::REG_KERNEL_MODE:  mode = v[0];
        c2d_pkg::REG_IMAGE_WIDTH:  width_reg = v[10:0];
        c2d_pkg::REG_IMAGE_HEIGHT: height_reg = v[10:0];
        c2d_pkg::REG_COEF_BANK0:   bank0 = v;
        c2d_pkg::REG_COEF_BANK1:   bank1 = v;
        c2d_pkg::REG_COEF_BANK2:   bank2 = v;
        c2d_pkg::REG_COEF_BANK3:   bank3 = v[7:0];
        default: ;
      endcase
    endfunction

    function int coef(int unsigned i);
      logic [63:0] b;
      logic [7:0]  byt;
      if (i < 8) b = bank0;
      else if (i < 16) b = bank1;
      else if (i < 24) b = bank2;
      else b = {56'd0, bank3};
      byt = b[(i % 8) * 8 +: 8];
      return $signed(byt);
    endfunction

    function int unsigned pending(); return expected_q.size(); endfunction

    // runs the convolution for one accepted item
    function void note_input(c2d_pkg::c2d_in_t d);
      int unsigned w, h, rad, sz, total, lag, p, k, r, c, lin;
      int rr, cc;
      longint sum;
      c2d_pkg::c2d_out_t e;
      w = eff_w(); h = eff_h(); rad = radius(); sz = 2 * rad + 1;
      total = w * h; lag = frame_lag(); sum = 0;
      if (seen >= total + lag) seen = 0;
      p = seen;
      if (p < total) pix_store[p % STORE_DEPTH] = (d.cmd == CMD_DRAIN) ? 8'd0 : d.pixel_in;
      seen = p + 1;
      if (p < lag) return;
      k = p - lag;
      if (k >= total) return;
      r = k / w; c = k % w;
      for (int a = 0; a < sz; a++) begin
        rr = int'(r) + a - int'(rad);
        if (rr < 0) rr = 0;
        if (rr >= int'(h)) rr = h - 1;
        for (int b = 0; b < sz; b++) begin
          cc = int'(c) + b - int'(rad);
          if (cc < 0) cc = 0;
          if (cc >= int'(w)) cc = w - 1;
          lin = rr * w + cc;
          sum += coef(a * sz + b) * int'(pix_store[lin % STORE_DEPTH]);
        end
      end
      e.filtered_value = sum[c2d_pkg::SUM_W-1:0];
      e.out_row = r[c2d_pkg::POS_W-1:0];
      e.out_col = c[c2d_pkg::POS_W-1:0];
      e.frame_end = (k == total - 1);
      if (k == total - 1) seen = 0;
      expected_q.push_back(e);
    endfunction

    function void check(c2d_pkg::c2d_out_t got);
      c2d_pkg::c2d_out_t e;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.filtered_value !== e.filtered_value || got.out_row !== e.out_row ||
          got.out_col !== e.out_col || got.frame_end !== e.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val %0d row %0d col %0d end %0b, %s %0d row %0d col %0d end %0b",
                   e.filtered_value, e.out_row, e.out_col, e.frame_end, "got val",
                   got.filtered_value, got.out_row, got.out_col, got.frame_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  c2d_pkg::c2d_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  c2d_pkg::c2d_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [c2d_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int items_sent = 0;
  int frames_done = 0;

  conv2d_clamped_edge dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[conv2d_clamped_edge] ERROR");
      $finish;
    end
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.cmd <= cmd;
    in_data.pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input c2d_pkg::c2d_reg_t idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(input logic m, input logic [10:0] w, input logic [10:0] h,
                           input logic [63:0] b0, input logic [63:0] b1,
                           input logic [63:0] b2, input logic [7:0] b3);
    drain_wait();
    cfg_write(c2d_pkg::REG_KERNEL_MODE, {63'd0, m});
    cfg_write(c2d_pkg::REG_IMAGE_WIDTH, {53'd0, w});
    cfg_write(c2d_pkg::REG_IMAGE_HEIGHT, {53'd0, h});
    cfg_write(c2d_pkg::REG_COEF_BANK0, b0);
    cfg_write(c2d_pkg::REG_COEF_BANK1, b1);
    cfg_write(c2d_pkg::REG_COEF_BANK2, b2);
    cfg_write(c2d_pkg::REG_COEF_BANK3, {56'd0, b3});
    cfg_valid <= 1'b0;
    repeat (8) @(negedge clk);
  endtask

  // one whole frame: pixels with the odd drain inside, then drains with the odd pixel
  task automatic run_frame(input bit fixed, input logic [7:0] fixed_pix);
    int unsigned total, lag;
    total = sb.eff_w() * sb.eff_h();
    lag = sb.frame_lag();
    for (int unsigned i = 0; i < total; i++)
      send_item(($urandom_range(19) == 0) ? CMD_DRAIN : CMD_PIXEL,
                fixed ? fixed_pix : 8'($urandom_range(255)));
    for (int unsigned i = 0; i < lag; i++)
      send_item(($urandom_range(4) == 0) ? CMD_PIXEL : CMD_DRAIN, 8'($urandom_range(255)));
    frames_done++;
  endtask

  // only the first items of a large frame; a small geometry afterwards restarts the count
  task automatic run_part(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(CMD_PIXEL, 8'($urandom_range(255)));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [10:0] pick_dim();
    case ($urandom_range(9))
      0: return 11'd1;
      1: return 11'd2;
      default: return 11'($urandom_range(3, 14));
    endcase
  endfunction

  initial begin
    int phase;
    int budget;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single pixel frames at the extremes, then a tiny frame
    configure(1'b0, 11'd1, 11'd1, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}}, 8'h7f);
    run_frame(1, 8'd255);
    configure(1'b1, 11'd1, 11'd1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 8'h80);
    run_frame(1, 8'd255);
    configure(1'b0, 11'd0, 11'd0, rand64(), rand64(), rand64(), 8'h80);
    run_frame(1, 8'd0);
    configure(1'b0, 11'd3, 11'd2, rand64(), rand64(), rand64(), 8'h01);
    send_item(CMD_PIXEL, 8'd0);
    send_item(CMD_DRAIN, 8'd77);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_PIXEL, 8'd128);
    send_item(CMD_PIXEL, 8'd1);
    send_item(CMD_PIXEL, 8'd254);
    send_item(CMD_PIXEL, 8'd99);
    send_item(CMD_DRAIN, 8'd0);
    send_item(CMD_PIXEL, 8'd5);
    send_item(CMD_DRAIN, 8'd0);

    // random phases, cycling the idling patterns
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      case (phase)
        4: configure(1'b1, 11'd48, 11'd3, rand64(), rand64(), rand64(), 8'($urandom()));
        6: configure(1'b0, 11'd2047, 11'd1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 8'h80);
        8: configure(1'b1, 11'd1, 11'd2047, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}}, 8'h7f);
        10: configure(1'b1, 11'd2, 11'd2047, rand64(), rand64(), rand64(), 8'($urandom()));
        default: configure(1'($urandom()), pick_dim(), pick_dim(),
                           rand64(), rand64(), rand64(), 8'($urandom()));
      endcase
      if (phase == 4) hold_req = 1;
      budget = items_sent + 70;
      if (phase == 6 || phase == 8 || phase == 10) begin
        run_part(100);
        configure(1'($urandom()), 11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)),
                  rand64(), rand64(), rand64(), 8'($urandom()));
      end
      run_frame(0, 8'd0);
      while (items_sent < budget) begin
        if ((phase % 4) == 0 && $urandom_range(2) == 0) begin
          // fresh small geometry between frames
          configure(1'($urandom()), pick_dim(), pick_dim(),
                    rand64(), rand64(), rand64(), 8'($urandom()));
        end
        run_frame(0, 8'd0);
      end
    end

    drain_wait();
    repeat (30) @(negedge clk);
    $display("covered %0d items in %0d frames, %0d results checked, %0d mismatches",
             items_sent, frames_done, sb.results_checked, sb.mismatches);
    $display("both kernel sizes, clamped and extreme image sizes, drains, stray pixels, restarts");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[conv2d_clamped_edge] OK");
    end else begin
      $display("[conv2d_clamped_edge] ERROR");
    end
    $finish;
  end

endmodule
